// ===== rtl/chm_pkg.sv =====
package chm_pkg;

  localparam int CORDIC_STAGES  = 16;
  localparam int ANG_TABLE_LEN  = 24;
  localparam int NUM_ITER       = (CORDIC_STAGES < ANG_TABLE_LEN) ? CORDIC_STAGES
                                                                  : ANG_TABLE_LEN;
  localparam int MAG_W          = 16;
  localparam int MAG_ABS_W      = MAG_W + 1;
  localparam int VEC_SCALE_BITS = 10;
  localparam int DATA_W         = 29;
  localparam int ANG_W          = 30;
  localparam int H_W            = 29;
  localparam int SCALED_W       = H_W + 4;
  localparam int FRAC_BITS      = 20;
  localparam int Q_W            = SCALED_W - FRAC_BITS;
  localparam int IDX_W          = 5;
  localparam int HEAD_W         = 12;

  typedef logic signed [DATA_W-1:0] vec_t;
  typedef logic signed [ANG_W-1:0]  ang_t;
  typedef logic [H_W-1:0]           hang_t;
  typedef logic [IDX_W-1:0]         idx_t;

  localparam ang_t  DEG90  = 30'sd94371840;
  localparam ang_t  DEG180 = 30'sd188743680;
  localparam ang_t  DEG360 = 30'sd377487360;
  localparam logic [SCALED_W-1:0] ROUND_HALF = SCALED_W'(1) << (FRAC_BITS - 1);
  localparam logic [Q_W-1:0]      OUT_MAX    = Q_W'(3600);

  typedef enum logic [1:0] {
    SPEC_NONE,
    SPEC_ZERO,
    SPEC_RIGHT
  } spec_t;

  typedef struct packed {
    vec_t  vx;
    vec_t  vy;
    ang_t  z;
    logic  x_neg;
    logic  y_neg;
    logic  z_neg;
    spec_t spec;
  } cordic_t;

  function automatic ang_t atan_tab(idx_t i);
    ang_t r;
    case (i)
      5'd0:    r = 30'sd47185920;
      5'd1:    r = 30'sd27855475;
      5'd2:    r = 30'sd14718068;
      5'd3:    r = 30'sd7471121;
      5'd4:    r = 30'sd3750058;
      5'd5:    r = 30'sd1876857;
      5'd6:    r = 30'sd938658;
      5'd7:    r = 30'sd469357;
      5'd8:    r = 30'sd234682;
      5'd9:    r = 30'sd117342;
      5'd10:   r = 30'sd58671;
      5'd11:   r = 30'sd29335;
      5'd12:   r = 30'sd14668;
      5'd13:   r = 30'sd7334;
      5'd14:   r = 30'sd3667;
      5'd15:   r = 30'sd1833;
      5'd16:   r = 30'sd917;
      5'd17:   r = 30'sd458;
      5'd18:   r = 30'sd229;
      5'd19:   r = 30'sd115;
      5'd20:   r = 30'sd57;
      5'd21:   r = 30'sd29;
      5'd22:   r = 30'sd14;
      5'd23:   r = 30'sd7;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/chm_if.sv =====
interface chm_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [chm_pkg::MAG_W-1:0]    mag_x;
  logic signed [chm_pkg::MAG_W-1:0]    mag_y;
  logic signed [chm_pkg::MAG_W-1:0]    mag_z;

  modport source (output valid, output mag_x, output mag_y, output mag_z, input ready);
  modport sink   (input valid, input mag_x, input mag_y, input mag_z, output ready);
endinterface

interface chm_out_if;
  logic                         valid;
  logic                         ready;
  logic [chm_pkg::HEAD_W-1:0]   heading_tenths;

  modport source (output valid, output heading_tenths, input ready);
  modport sink   (input valid, input heading_tenths, output ready);
endinterface

// ===== rtl/chm_prep.sv =====
module chm_prep (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              en,
  input  logic                              in_valid,
  input  logic signed [chm_pkg::MAG_W-1:0]  mag_x,
  input  logic signed [chm_pkg::MAG_W-1:0]  mag_y,
  input  logic signed [chm_pkg::MAG_W-1:0]  mag_z,
  output logic                              valid_r,
  output chm_pkg::cordic_t                  data_r
);

  logic signed [chm_pkg::MAG_ABS_W-1:0] x_ext;
  logic signed [chm_pkg::MAG_ABS_W-1:0] y_ext;
  logic [chm_pkg::MAG_ABS_W-1:0]        rise;
  logic [chm_pkg::MAG_ABS_W-1:0]        run;
  chm_pkg::cordic_t                     data_nxt;

  always_comb begin
    x_ext = chm_pkg::MAG_ABS_W'(mag_x);
    y_ext = chm_pkg::MAG_ABS_W'(mag_y);
    rise  = mag_x[chm_pkg::MAG_W-1] ? unsigned'(-x_ext) : unsigned'(x_ext);
    run   = mag_y[chm_pkg::MAG_W-1] ? unsigned'(-y_ext) : unsigned'(y_ext);
    data_nxt.vx    = chm_pkg::vec_t'(run) <<< chm_pkg::VEC_SCALE_BITS;
    data_nxt.vy    = chm_pkg::vec_t'(rise) <<< chm_pkg::VEC_SCALE_BITS;
    data_nxt.z     = '0;
    data_nxt.x_neg = mag_x[chm_pkg::MAG_W-1];
    data_nxt.y_neg = mag_y[chm_pkg::MAG_W-1];
    data_nxt.z_neg = mag_z[chm_pkg::MAG_W-1];
    if (mag_x == '0) begin
      data_nxt.spec = chm_pkg::SPEC_ZERO;
    end else if (mag_y == '0) begin
      data_nxt.spec = chm_pkg::SPEC_RIGHT;
    end else begin
      data_nxt.spec = chm_pkg::SPEC_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_r <= data_nxt;
    end
  end

endmodule

// ===== rtl/chm_cordic_stage.sv =====
module chm_cordic_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  chm_pkg::idx_t     stage_idx,
  input  logic              in_valid,
  input  chm_pkg::cordic_t  in_data,
  output logic              valid_r,
  output chm_pkg::cordic_t  data_r
);

  chm_pkg::vec_t    dx;
  chm_pkg::vec_t    dy;
  chm_pkg::ang_t    step;
  chm_pkg::cordic_t data_nxt;

  always_comb begin
    dx       = in_data.vy >>> stage_idx;
    dy       = in_data.vx >>> stage_idx;
    step     = chm_pkg::atan_tab(stage_idx);
    data_nxt = in_data;
    if (!in_data.vy[chm_pkg::DATA_W-1]) begin
      data_nxt.vx = in_data.vx + dx;
      data_nxt.vy = in_data.vy - dy;
      data_nxt.z  = in_data.z + step;
    end else begin
      data_nxt.vx = in_data.vx - dx;
      data_nxt.vy = in_data.vy + dy;
      data_nxt.z  = in_data.z - step;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_r <= data_nxt;
    end
  end

endmodule

// ===== rtl/chm_post.sv =====
module chm_post (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en_a,
  input  logic                         en_b,
  input  logic                         in_valid,
  input  chm_pkg::cordic_t             in_data,
  output logic                         valid_a_r,
  output logic                         valid_b_r,
  output logic [chm_pkg::HEAD_W-1:0]   heading_r
);

  chm_pkg::ang_t                      t;
  chm_pkg::ang_t                      base;
  chm_pkg::ang_t                      sum;
  logic                               neg;
  chm_pkg::hang_t                     h_r;
  chm_pkg::hang_t                     h_nxt;
  logic [chm_pkg::SCALED_W-1:0]       scaled;
  logic [chm_pkg::Q_W-1:0]            q;
  logic [chm_pkg::HEAD_W-1:0]         heading_nxt;

  always_comb begin
    case (in_data.spec)
      chm_pkg::SPEC_ZERO:  t = '0;
      chm_pkg::SPEC_RIGHT: t = chm_pkg::DEG90;
      default: begin
        if (in_data.z < 0) begin
          t = '0;
        end else if (in_data.z > chm_pkg::DEG90) begin
          t = chm_pkg::DEG90;
        end else begin
          t = in_data.z;
        end
      end
    endcase
    // The mirror for a negative Z flips the sign of t and swaps 0 and 360.
    neg = in_data.x_neg ^ in_data.y_neg ^ in_data.z_neg;
    if (in_data.y_neg) begin
      base = chm_pkg::DEG180;
    end else if (neg) begin
      base = chm_pkg::DEG360;
    end else begin
      base = '0;
    end
    sum   = neg ? (base - t) : (base + t);
    h_nxt = sum[chm_pkg::H_W-1:0];
  end

  always_comb begin
    scaled = (chm_pkg::SCALED_W'(h_r) << 3) + (chm_pkg::SCALED_W'(h_r) << 1)
           + chm_pkg::ROUND_HALF;
    q      = scaled[chm_pkg::SCALED_W-1:chm_pkg::FRAC_BITS];
    heading_nxt = (q > chm_pkg::OUT_MAX) ? chm_pkg::OUT_MAX[chm_pkg::HEAD_W-1:0]
                                         : q[chm_pkg::HEAD_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_a_r <= 1'b0;
      valid_b_r <= 1'b0;
    end else begin
      if (en_a) begin
        valid_a_r <= in_valid;
      end
      if (en_b) begin
        valid_b_r <= valid_a_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en_a) begin
      h_r <= h_nxt;
    end
    if (en_b) begin
      heading_r <= heading_nxt;
    end
  end

endmodule

// ===== rtl/compass_heading_from_magnetometer.sv =====
// Compass heading from one signed magnetometer sample (X, Y, Z), given in tenths of a
// degree from 0 to 3600 and rounded half up; X and Y select the angle through CORDIC
// vectoring in fixed point, and a negative Z mirrors the heading to 360 minus it.
// The block takes one transaction per clock unless a stalled output has filled every
// stage. Each result passes a register that folds the sample into the first quadrant,
// one register per CORDIC iteration, one that maps the quadrant, and the output
// register, where it is scaled and rounded. Every stage holds its own valid bit, so a
// stalled output backs up only as far as empty stages allow and bubbles are squeezed out.
module compass_heading_from_magnetometer (
  input  logic        clk,
  input  logic        rst_n,
  chm_in_if.sink      in_if,
  chm_out_if.source   out_if
);

  logic [chm_pkg::NUM_ITER:0]  stg_valid;
  logic [chm_pkg::NUM_ITER:0]  stg_en;
  chm_pkg::cordic_t            stg_data [chm_pkg::NUM_ITER+1];
  logic                        valid_a;
  logic                        valid_b;
  logic                        en_a;
  logic                        en_b;

  assign en_b = !valid_b || out_if.ready;
  assign en_a = !valid_a || en_b;
  assign stg_en[chm_pkg::NUM_ITER] = !stg_valid[chm_pkg::NUM_ITER] || en_a;

  genvar k;
  generate
    for (k = 0; k < chm_pkg::NUM_ITER; k++) begin : g_en
      assign stg_en[k] = !stg_valid[k] || stg_en[k+1];
    end
  endgenerate

  assign in_if.ready  = stg_en[0];
  assign out_if.valid = valid_b;

  chm_prep u_prep (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (stg_en[0]),
    .in_valid (in_if.valid),
    .mag_x    (in_if.mag_x),
    .mag_y    (in_if.mag_y),
    .mag_z    (in_if.mag_z),
    .valid_r  (stg_valid[0]),
    .data_r   (stg_data[0])
  );

  generate
    for (k = 0; k < chm_pkg::NUM_ITER; k++) begin : g_iter
      chm_cordic_stage u_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (stg_en[k+1]),
        .stage_idx (chm_pkg::idx_t'(k)),
        .in_valid  (stg_valid[k]),
        .in_data   (stg_data[k]),
        .valid_r   (stg_valid[k+1]),
        .data_r    (stg_data[k+1])
      );
    end
  endgenerate

  chm_post u_post (
    .clk       (clk),
    .rst_n     (rst_n),
    .en_a      (en_a),
    .en_b      (en_b),
    .in_valid  (stg_valid[chm_pkg::NUM_ITER]),
    .in_data   (stg_data[chm_pkg::NUM_ITER]),
    .valid_a_r (valid_a),
    .valid_b_r (valid_b),
    .heading_r (out_if.heading_tenths)
  );

  a_heading_range: assert property (@(posedge clk) disable iff (!rst_n)
    valid_b |-> out_if.heading_tenths <= chm_pkg::OUT_MAX[chm_pkg::HEAD_W-1:0])
    else $error("heading above 3600");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !valid_b |-> in_if.ready)
    else $error("input stalled with an empty output register");

  a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (in_if.valid && in_if.ready) |=> stg_valid[0])
    else $error("accepted transaction missing from the first stage");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_a && !en_a) |=> valid_a)
    else $error("stalled quadrant stage dropped its transaction");

endmodule
